/* rtl/cbsp_pkg.sv */
// ----------------------------------------------------------------------------
// cbsp_pkg
// Shared types and constants of the base32 CID string parser.
// ----------------------------------------------------------------------------
package cbsp_pkg;

  localparam int unsigned CidBytesDefault = 36;

  // Stream payload widths.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 2;

  // Characters of the multibase prefix and the base32 alphabet.
  localparam logic [7:0] PrefixChar   = 8'h62;
  localparam logic [7:0] CharLowA     = 8'h61;
  localparam logic [7:0] CharLowZ     = 8'h7a;
  localparam logic [7:0] CharDigit2   = 8'h32;
  localparam logic [7:0] CharDigit7   = 8'h37;
  // '2' maps to the value 26, so digits are offset by 0x32 - 26.
  localparam logic [7:0] DigitOffset  = 8'h18;

  // Expected CID header bytes.
  localparam logic [7:0] HdrVersion   = 8'h01;
  localparam logic [7:0] HdrCodecCbor = 8'h71;
  localparam logic [7:0] HdrCodecRaw  = 8'h55;
  localparam logic [7:0] HdrHashSha   = 8'h12;
  localparam logic [7:0] HdrHashLen   = 8'h20;

  localparam logic [5:0] CountMax     = 6'd63;

  // Completion status codes.
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  typedef struct packed {
    logic        prefix_seen;
    logic [11:0] acc;
    logic [3:0]  pend;
    logic [5:0]  count;
    logic        err;
    logic        header_ok;
  } cbsp_state_t;

  localparam cbsp_state_t StateReset = '{
    prefix_seen: 1'b0,
    acc:         12'd0,
    pend:        4'd0,
    count:       6'd0,
    err:         1'b0,
    header_ok:   1'b1
  };

  typedef struct packed {
    logic       emit;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       string_done;
    logic       parse_status;
  } cbsp_result_t;

endpackage

/* rtl/cbsp_step.sv */
// ----------------------------------------------------------------------------
// cbsp_step
// Combinational decode of one character: next parser state and the result.
// ----------------------------------------------------------------------------
module cbsp_step #(
  parameter int unsigned CID_BYTES = cbsp_pkg::CidBytesDefault
) (
  input  cbsp_pkg::cbsp_state_t  state_i,
  input  logic [7:0]             char_i,
  input  logic                   last_i,
  output cbsp_pkg::cbsp_state_t  state_o,
  output cbsp_pkg::cbsp_result_t result_o
);
  import cbsp_pkg::*;

  logic        is_letter;
  logic        is_digit;
  logic [4:0]  digit_val;
  logic [11:0] acc_shift;
  logic [3:0]  pend_sum;
  logic [3:0]  pend_left;
  logic        byte_done;
  logic [7:0]  byte_val;
  logic        str_ok;
  cbsp_state_t  nxt;
  cbsp_result_t res;

  assign is_letter = (char_i >= CharLowA) && (char_i <= CharLowZ);
  assign is_digit  = (char_i >= CharDigit2) && (char_i <= CharDigit7);
  assign digit_val = is_letter ? 5'(char_i - CharLowA) : 5'(char_i - DigitOffset);
  assign acc_shift = {state_i.acc[6:0], digit_val};
  assign pend_sum  = state_i.pend + 4'd5;
  assign byte_done = pend_sum >= 4'd8;
  assign pend_left = pend_sum - 4'd8;
  assign byte_val  = 8'(acc_shift >> pend_left[2:0]);

  always_comb begin
    nxt    = state_i;
    res    = '0;
    str_ok = 1'b0;
    if (!state_i.prefix_seen) begin
      nxt.prefix_seen = 1'b1;
      if (char_i != PrefixChar) begin
        nxt.err = 1'b1;
      end
    end else if (!state_i.err) begin
      if (!(is_letter || is_digit)) begin
        nxt.err = 1'b1;
      end else begin
        nxt.acc = acc_shift;
        if (byte_done) begin
          nxt.pend = pend_left;
          if (state_i.count == CountMax) begin
            nxt.err = 1'b1;
          end else begin
            res.byte_valid = 1'b1;
            res.data_byte  = byte_val;
            res.byte_index = state_i.count;
            nxt.count      = state_i.count + 6'd1;
            case (state_i.count)
              6'd0: begin
                if (byte_val != HdrVersion) nxt.header_ok = 1'b0;
              end
              6'd1: begin
                if (byte_val != HdrCodecCbor && byte_val != HdrCodecRaw) begin
                  nxt.header_ok = 1'b0;
                end
              end
              6'd2: begin
                if (byte_val != HdrHashSha) nxt.header_ok = 1'b0;
              end
              6'd3: begin
                if (byte_val != HdrHashLen) nxt.header_ok = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end else begin
          nxt.pend = pend_sum;
        end
      end
    end

    str_ok = !nxt.err && nxt.header_ok && (nxt.count == 6'(CID_BYTES));
    if (last_i) begin
      res.string_done  = 1'b1;
      res.parse_status = str_ok ? StatusOk : StatusInvalid;
      nxt              = StateReset;
    end
    res.emit = res.byte_valid || last_i;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

/* rtl/cid_base32_string_parser.sv */
// ----------------------------------------------------------------------------
// cid_base32_string_parser
// Decodes a lowercase base32 multibase CID string into its bytes and checks it.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] char_code, tlast final_char
// m_axis    out  tdata[7:0] data_byte, tdata[13:8] byte_index, tdata[15:14] zero,
//                tuser[0] byte_valid, tuser[1] parse_status, tlast string_done
//
// Each character is taken into an input register, decoded combinationally and
// written to a result register, so a result reaches the master side through
// these two registers. The block takes one character per cycle unless a full
// result register stalls it. The short decode path from the input register to
// the result register sets that rate.
// A character that completes no byte and is not the last one makes no result
// and never waits for the output side. While the result register is full and
// not taken, a character that would produce a result holds in the input
// register and the slave side stalls. Reset empties both registers and returns
// the parser to the start of a string.
//
module cid_base32_string_parser #(
  parameter int unsigned CID_BYTES = cbsp_pkg::CidBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cbsp_pkg::InDataW-1:0]   s_axis_tdata,   // [7:0] char_code
  input  logic                           s_axis_tlast,   // final_char
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cbsp_pkg::OutDataW-1:0]  m_axis_tdata,   // [7:0] data_byte,
                                                         // [13:8] byte_index
  output logic [cbsp_pkg::OutUserW-1:0]  m_axis_tuser,   // [0] byte_valid,
                                                         // [1] parse_status
  output logic                           m_axis_tlast    // string_done
);
  import cbsp_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic       in_valid_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Parser state carried between characters.
  cbsp_state_t  state_q;
  cbsp_state_t  state_d;
  cbsp_result_t step_res;

  // Result register.
  logic                out_valid_q;
  logic                out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic                out_last_q;

  logic out_free;
  logic advance;

  cbsp_step #(
    .CID_BYTES (CID_BYTES)
  ) u_cbsp_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The held character moves on when it makes no result or the result
  // register is free this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (out_free || !step_res.emit);
  assign s_axis_tready = !in_valid_q || advance;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = (advance && step_res.emit) ? 1'b1
                     : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata[7:0];
      in_last_q <= s_axis_tlast;
    end
    if (advance && step_res.emit) begin
      out_data_q <= {2'b00, step_res.byte_index, step_res.data_byte};
      out_user_q <= {step_res.parse_status, step_res.byte_valid};
      out_last_q <= step_res.string_done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/cbsp_checker.sv */
// ----------------------------------------------------------------------------
// cbsp_checker
// Port-level checks of the base32 CID string parser, bound to its top level.
// ----------------------------------------------------------------------------
module cbsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [cbsp_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cbsp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [cbsp_pkg::OutUserW-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);
  import cbsp_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Every result carries a byte, a string end, or both.
  a_out_useful: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
    else $error("empty result");

  // The status is only reported on the end of a string.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[1] == StatusOk)
    else $error("status without string end");

  // A result without a byte carries zero byte fields.
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("byte fields set without a byte");

endmodule

bind cid_base32_string_parser cbsp_checker u_cbsp_checker (.*);

/* tb/tb_cid_base32_string_parser.sv */
// ----------------------------------------------------------------------------
// tb_cid_base32_string_parser
// Self-checking stream testbench for the base32 CID string parser.
// ----------------------------------------------------------------------------
// A queue of characters is built at time zero. It starts with a few short
// strings that hit the alphabet edges and the prefix and end cases. Random
// strings follow. Most of them are proper CIDv1 strings with random content.
// The rest carry a damaged header, a wrong length, a stray character, a wrong
// prefix, too many bytes, or plain noise. A clocked driver hands the
// characters to the slave side with random gaps. A clocked monitor feeds every
// accepted character to a local copy of the decoder and checks each result on
// the master side against the oldest one still due. The receiver stalls at
// random, and once it holds off for a long stretch so that the parser fills up
// and stalls its input.
// ----------------------------------------------------------------------------

module tb_cid_base32_string_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import cbsp_pkg::*;

  localparam int CidBytes   = CidBytesDefault;
  localparam int ItemTarget = 1250;
  localparam int CycleLimit = 500000;
  localparam int HoldAfter  = 500;   // accepted items before the long hold-off
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 8;

  // One character waiting to be driven, with the idle cycles that precede it.
  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    logic [3:0] gap;
  } char_item_t;

  // One result of the parser, split into its fields.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       string_done;
    logic       parse_status;
  } cid_out_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [OutUserW-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  cid_base32_string_parser #(
    .CID_BYTES(CidBytes)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .s_axis_tlast  (s_axis_tlast),   // final_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [13:8] byte_index
    .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] parse_status
    .m_axis_tlast  (m_axis_tlast)    // string_done
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and scoreboard storage.
  char_item_t char_q[$];
  cid_out_t   due_results[$];
  logic [7:0] raw_bytes[$];   // CID bytes of the string under construction
  logic [7:0] text[$];        // characters of the string under construction

  // Handshake records, written only by the monitor at the rising edge.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  int   n_accepted = 0;
  int   n_items    = 0;
  int   n_fail     = 0;
  int   cycle_cnt  = 0;

  // Driver, receiver and hold-off state.
  bit         tx_calm   = 1'b0;
  bit         staged    = 1'b0;
  char_item_t staged_item;
  int         wait_cnt  = 0;
  bit         rx_calm   = 1'b0;
  int         rx_wait   = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Decoder state of the local prediction.
  logic        dec_pfx;
  logic [11:0] dec_acc;
  logic [3:0]  dec_pend;
  logic [5:0]  dec_count;
  logic        dec_err;
  logic        dec_hdr_ok;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic bit in_alphabet(input logic [7:0] c);
    return (c >= CharLowA && c <= CharLowZ) || (c >= CharDigit2 && c <= CharDigit7);
  endfunction

  function automatic logic [7:0] digit_char(input logic [4:0] v);
    return (v < 5'd26) ? CharLowA + 8'(v) : 8'(v) + DigitOffset;
  endfunction

  task automatic clear_decoder();
    dec_pfx    = 1'b0;
    dec_acc    = '0;
    dec_pend   = '0;
    dec_count  = '0;
    dec_err    = 1'b0;
    dec_hdr_ok = 1'b1;
  endtask

  // Runs one accepted character through the decoder and queues the result
  // that it causes, if any.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    cid_out_t   res;
    logic [4:0] val;
    res = '0;
    if (!dec_pfx) begin
      // The first character of a string only has to be the prefix.
      dec_pfx = 1'b1;
      if (c != PrefixChar) dec_err = 1'b1;
    end else if (!dec_err) begin
      if (!in_alphabet(c)) begin
        dec_err = 1'b1;
      end else begin
        val      = (c >= CharLowA) ? 5'(c - CharLowA) : 5'(c - DigitOffset);
        dec_acc  = {dec_acc[6:0], val};
        dec_pend = dec_pend + 4'd5;
        if (dec_pend >= 4'd8) begin
          dec_pend = dec_pend - 4'd8;
          if (dec_count >= CountMax) begin
            // Too many bytes: the byte is dropped and the string is spoiled.
            dec_err = 1'b1;
          end else begin
            res.byte_valid = 1'b1;
            res.data_byte  = 8'(dec_acc >> dec_pend);
            res.byte_index = dec_count;
            case (dec_count)
              6'd0: if (res.data_byte != HdrVersion) dec_hdr_ok = 1'b0;
              6'd1: begin
                if (res.data_byte != HdrCodecCbor && res.data_byte != HdrCodecRaw)
                  dec_hdr_ok = 1'b0;
              end
              6'd2: if (res.data_byte != HdrHashSha) dec_hdr_ok = 1'b0;
              6'd3: if (res.data_byte != HdrHashLen) dec_hdr_ok = 1'b0;
              default: ;
            endcase
            dec_count = dec_count + 6'd1;
          end
        end
      end
    end
    if (fin) begin
      res.string_done  = 1'b1;
      res.parse_status = (!dec_err && dec_hdr_ok && dec_count == 6'(CidBytes)) ?
                         StatusOk : StatusInvalid;
      clear_decoder();
    end
    if (res.byte_valid || res.string_done) due_results.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  // Queues one character; the gap before it follows the current string mode.
  task automatic say(input logic [7:0] c, input logic fin);
    char_item_t it;
    it.code = c;
    it.fin  = fin;
    it.gap  = tx_calm ? 4'd0 : 4'($urandom_range(0, 15));
    char_q.push_back(it);
  endtask

  task automatic build_payload(input int nbytes);
    raw_bytes.delete();
    for (int i = 0; i < nbytes; i++) raw_bytes.push_back(8'($urandom_range(0, 255)));
    if (nbytes > 0) raw_bytes[0] = HdrVersion;
    if (nbytes > 1) raw_bytes[1] = $urandom_range(0, 1) ? HdrCodecCbor : HdrCodecRaw;
    if (nbytes > 2) raw_bytes[2] = HdrHashSha;
    if (nbytes > 3) raw_bytes[3] = HdrHashLen;
  endtask

  // Turns raw_bytes into prefix plus base32 text. The unused low bits of the
  // last digit are random, since the parser must drop them anyway.
  task automatic encode_payload();
    int unsigned pool;
    int          nbits;
    int          spare;
    logic [4:0]  v;
    text.delete();
    text.push_back(PrefixChar);
    pool  = 0;
    nbits = 0;
    foreach (raw_bytes[i]) begin
      pool  = (pool << 8) | raw_bytes[i];
      nbits = nbits + 8;
      while (nbits >= 5) begin
        nbits = nbits - 5;
        v = 5'((pool >> nbits) & 31);
        text.push_back(digit_char(v));
      end
      pool = pool & ((1 << nbits) - 1);
    end
    if (nbits != 0) begin
      spare = 5 - nbits;
      v = 5'((pool << spare) | $urandom_range(0, (1 << spare) - 1));
      text.push_back(digit_char(v));
    end
  endtask

  task automatic ship_text();
    tx_calm = ($urandom_range(0, 4) == 0);
    foreach (text[i]) say(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (in_alphabet(c));
    return c;
  endfunction

  task automatic note_failure(input string what);
    n_fail++;
    if (n_fail <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next character at the falling edge once the previous
  // one was taken and its gap has run out. A character that is taken with no
  // gap before the next one keeps tvalid high without a dip.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    logic nv;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid && !in_fire;
      if (!nv) begin
        if (!staged && char_q.size() != 0) begin
          staged_item = char_q.pop_front();
          staged      = 1'b1;
          wait_cnt    = staged_item.gap;
        end
        if (staged) begin
          if (wait_cnt != 0) begin
            wait_cnt = wait_cnt - 1;
          end else begin
            nv = 1'b1;
            s_axis_tdata <= staged_item.code;
            s_axis_tlast <= staged_item.fin;
            staged = 1'b0;
          end
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: after every taken result it draws a stall; now and then it
  // switches to stretches without stalls. The long hold-off overrides both.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long hold-off on the master side, started once enough characters went in.
  // The driver keeps offering characters meanwhile, so the input side stalls.
  always @(posedge clk_i) begin : backpressure
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_accepted >= HoldAfter) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge, checks results in
  // order and predicts the results of accepted characters.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    cid_out_t got;
    cid_out_t want;
    if (!rst_ni) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_valid   = m_axis_tuser[0];
        got.data_byte    = m_axis_tdata[7:0];
        got.byte_index   = m_axis_tdata[13:8];
        got.string_done  = m_axis_tlast;
        got.parse_status = m_axis_tuser[1];
        if (due_results.size() == 0) begin
          note_failure($sformatf("unexpected result: valid=%0b byte=%02h idx=%0d done=%0b st=%0b",
                                 got.byte_valid, got.data_byte, got.byte_index,
                                 got.string_done, got.parse_status));
        end else begin
          want = due_results.pop_front();
          if (got.byte_valid   !== want.byte_valid  || got.data_byte    !== want.data_byte ||
              got.byte_index   !== want.byte_index  || got.string_done  !== want.string_done ||
              got.parse_status !== want.parse_status) begin
            note_failure($sformatf(
              "mismatch: expected valid=%0b byte=%02h idx=%0d done=%0b st=%0b, got %0b %02h %0d %0b %0b",
              want.byte_valid, want.data_byte, want.byte_index, want.string_done,
              want.parse_status, got.byte_valid, got.data_byte, got.byte_index,
              got.string_done, got.parse_status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tlast);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         kind;
    int         len;
    bit         first;
    logic [7:0] c;

    clear_decoder();

    // Directed strings. A lone prefix, a lone other character and a lone zero
    // code all finish with no bytes and must report invalid.
    say(PrefixChar, 1'b1);
    say(8'h78, 1'b1);
    say(8'h00, 1'b1);
    // Wrong prefix followed by a proper digit.
    say(8'hff, 1'b0);
    say(CharLowA, 1'b1);
    // Alphabet edges, two completed bytes, then the code just below 'a' spoils
    // the string and the following digit must be ignored.
    say(PrefixChar, 1'b0);
    say(CharDigit7, 1'b0);
    say(CharLowZ, 1'b0);
    say(CharLowA, 1'b0);
    say(CharDigit2, 1'b0);
    say(8'h60, 1'b0);
    say(CharLowA, 1'b1);
    // Codes just outside the alphabet and the code 0xff, each one the last of its string.
    say(PrefixChar, 1'b0);
    say(8'h7b, 1'b1);
    say(PrefixChar, 1'b0);
    say(8'h31, 1'b1);
    say(PrefixChar, 1'b0);
    say(8'h38, 1'b1);
    say(PrefixChar, 1'b0);
    say(8'hff, 1'b1);

    // Random strings, mostly well formed. The first one carries 63 to 70 bytes.
    first = 1'b1;
    while (char_q.size() < ItemTarget) begin
      kind  = first ? 87 : $urandom_range(0, 99);
      first = 1'b0;
      if (kind < 55) begin
        build_payload(CidBytes);
        encode_payload();
      end else if (kind < 65) begin
        build_payload(CidBytes);
        raw_bytes[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        encode_payload();
      end else if (kind < 75) begin
        build_payload($urandom_range(0, 45));
        encode_payload();
      end else if (kind < 83) begin
        build_payload(CidBytes);
        encode_payload();
        text[$urandom_range(1, text.size() - 1)] = pick_bad();
      end else if (kind < 87) begin
        build_payload(CidBytes);
        encode_payload();
        do c = 8'($urandom_range(0, 255)); while (c == PrefixChar);
        text[0] = c;
      end else if (kind < 90) begin
        build_payload($urandom_range(63, 70));
        encode_payload();
      end else begin
        // Noise: short strings of mixed digits and arbitrary codes.
        text.delete();
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if (i == 0 && $urandom_range(0, 1)) c = PrefixChar;
          else if ($urandom_range(0, 1)) c = digit_char(5'($urandom_range(0, 31)));
          else c = 8'($urandom_range(0, 255));
          text.push_back(c);
        end
      end
      ship_text();
    end
    n_items = char_q.size();

    // Reset, released at a falling edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_items) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    // Give a stray extra result the chance to show up.
    repeat (DrainCycles) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* cid_base32_string_parser.f */
rtl/cbsp_pkg.sv
rtl/cbsp_step.sv
rtl/cid_base32_string_parser.sv
rtl/cbsp_checker.sv
tb/tb_cid_base32_string_parser.sv
